FILE: rtl/plrle_pkg.sv
// shared types, constants and the plane-to-channel mapping of the planar run-length image decoder
`timescale 1ns / 1ps

package plrle_pkg;

    // size limits, as 13-bit values
    localparam logic [12:0] MAX_WIDTH  = 13'd4096;
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    // code byte fields
    localparam int unsigned CODE_FILL_BIT = 7;
    localparam int unsigned CODE_LONG_BIT = 6;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_CHANNEL_COUNT = 3'd2,
        CFG_RLE_MODE      = 3'd3
    } t_cfg_index;

    // parser phases, one-hot
    typedef enum logic [3:0] {
        PH_CODE = 4'b0001,
        PH_LOW  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_SKIP = 4'b1000
    } t_phase;

    // one decoded run
    typedef struct packed {
        logic [7:0]  out_value;
        logic [13:0] run_length;
        logic [11:0] out_row;
        logic [11:0] out_col;
        logic [1:0]  out_channel;
        logic        image_last;
        logic        overrun_error;
    } t_run;

    // planes 0 and 2 trade places (bgr to rgb)
    function automatic logic [1:0] plane_to_channel(input logic [1:0] plane);
        logic [1:0] chan;
        chan = plane;
        if (plane == 2'd0) begin
            chan = 2'd2;
        end else if (plane == 2'd2) begin
            chan = 2'd0;
        end
        return chan;
    endfunction

endpackage

FILE: rtl/planar_rle_image_decoder_top.sv
// top level of the planar run-length image decoder
`timescale 1ns / 1ps

// Planar run-length image decoder. One compressed byte is taken per clock
// (i_valid high, o_stall low) and at most one run comes out per byte,
// registered. All parsing for a byte is a single pass through the phase,
// column, plane and row counters, so the sustained rate is one byte per cycle
// for any stream; only a stall on the result side that fills both the result
// register and the skid stage behind it holds the input off. Configuration
// writes to indexes 0 to 3 also clear the parser and all position counters
// and are meant to be issued only while the block is idle.
module planar_rle_image_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    // compressed byte stream
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    // decoded runs
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_value,
    output logic [13:0] o_run_length,
    output logic [11:0] o_out_row,
    output logic [11:0] o_out_col,
    output logic [1:0]  o_out_channel,
    output logic        o_image_last,
    output logic        o_overrun_error
);

    // configuration registers
    logic [12:0] r_image_width,   n_image_width;
    logic [12:0] r_image_height,  n_image_height;
    logic [2:0]  r_channel_count, n_channel_count;
    logic        r_rle_mode,      n_rle_mode;

    // parser state
    plrle_pkg::t_phase r_phase, n_phase;
    logic [13:0] r_run_remaining,   n_run_remaining;
    logic        r_run_is_fill,     n_run_is_fill;
    logic [11:0] r_col,             n_col;
    logic [1:0]  r_plane,           n_plane;
    logic [11:0] r_row,             n_row;
    logic        r_overrun_pending, n_overrun_pending;

    // result register and skid stage
    plrle_pkg::t_run r_out, n_out;
    plrle_pkg::t_run r_skid, n_skid;
    logic            r_out_valid,  n_out_valid;
    logic            r_skid_valid, n_skid_valid;

    // effective sizes and shared counter arithmetic
    logic [12:0] eff_width;
    logic [12:0] eff_height;
    logic [2:0]  eff_chan;
    logic [12:0] rem;
    logic        fill_clip;
    logic [12:0] fill_len;
    logic [12:0] adv_len;
    logic [12:0] col_sum;
    logic        col_done;
    logic [12:0] row_inc;
    logic        row_wrap;
    logic [2:0]  plane_inc;
    logic        plane_wrap;
    logic [13:0] start_count;
    logic        start_fill;
    logic [13:0] rr_dec;

    logic            accept;
    logic            res_valid;
    plrle_pkg::t_run res;
    logic            out_take;

    assign accept   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;

    // clamp the configured sizes
    always_comb begin
        if (r_image_width == 13'd0) begin
            eff_width = 13'd1;
        end else if (r_image_width > plrle_pkg::MAX_WIDTH) begin
            eff_width = plrle_pkg::MAX_WIDTH;
        end else begin
            eff_width = r_image_width;
        end
        if (r_image_height == 13'd0) begin
            eff_height = 13'd1;
        end else if (r_image_height > plrle_pkg::MAX_HEIGHT) begin
            eff_height = plrle_pkg::MAX_HEIGHT;
        end else begin
            eff_height = r_image_height;
        end
        eff_chan = (r_channel_count <= 3'd3) ? 3'd3 : 3'd4;
    end

    // position arithmetic shared by all phases
    always_comb begin
        rem        = eff_width - {1'b0, r_col};
        fill_clip  = r_run_remaining > {1'b0, rem};
        fill_len   = fill_clip ? rem : r_run_remaining[12:0];
        adv_len    = (r_rle_mode && r_run_is_fill) ? fill_len : 13'd1;
        col_sum    = {1'b0, r_col} + adv_len;
        col_done   = col_sum >= eff_width;
        row_inc    = {1'b0, r_row} + 13'd1;
        row_wrap   = row_inc >= eff_height;
        plane_inc  = {1'b0, r_plane} + 3'd1;
        plane_wrap = plane_inc >= eff_chan;
        rr_dec     = r_run_remaining - 14'd1;
        if (r_phase == plrle_pkg::PH_CODE) begin
            start_count = {8'd0, i_data_byte[5:0]};
            start_fill  = i_data_byte[plrle_pkg::CODE_FILL_BIT];
        end else begin
            start_count = {r_run_remaining[5:0], i_data_byte};
            start_fill  = r_run_is_fill;
        end
    end

    // configuration writes, per-byte parse and run generation
    always_comb begin
        n_image_width     = r_image_width;
        n_image_height    = r_image_height;
        n_channel_count   = r_channel_count;
        n_rle_mode        = r_rle_mode;
        n_phase           = r_phase;
        n_run_remaining   = r_run_remaining;
        n_run_is_fill     = r_run_is_fill;
        n_col             = r_col;
        n_plane           = r_plane;
        n_row             = r_row;
        n_overrun_pending = r_overrun_pending;
        res_valid         = 1'b0;
        res.out_value     = i_data_byte;
        res.run_length    = 14'd1;
        res.out_row       = r_row;
        res.out_col       = r_col;
        res.out_channel   = plrle_pkg::plane_to_channel(r_plane);
        res.image_last    = 1'b0;
        res.overrun_error = 1'b0;

        if (i_cfg_we) begin
            // a register write also restarts the image
            unique case (i_cfg_index)
                plrle_pkg::CFG_IMAGE_WIDTH:   n_image_width   = i_cfg_data;
                plrle_pkg::CFG_IMAGE_HEIGHT:  n_image_height  = i_cfg_data;
                plrle_pkg::CFG_CHANNEL_COUNT: n_channel_count = i_cfg_data[2:0];
                plrle_pkg::CFG_RLE_MODE:      n_rle_mode      = i_cfg_data[0];
                default: ;
            endcase
            if (i_cfg_index <= plrle_pkg::CFG_RLE_MODE) begin
                n_phase           = plrle_pkg::PH_CODE;
                n_run_remaining   = 14'd0;
                n_run_is_fill     = 1'b0;
                n_col             = 12'd0;
                n_plane           = 2'd0;
                n_row             = 12'd0;
                n_overrun_pending = 1'b0;
            end
        end else if (accept && !r_rle_mode) begin
            // raw interleaved copy
            res_valid       = 1'b1;
            res.out_channel = r_plane;
            n_plane         = plane_inc[1:0];
            if (plane_wrap) begin
                n_plane = 2'd0;
                n_col   = col_sum[11:0];
                if (col_done) begin
                    n_col          = 12'd0;
                    n_row          = row_wrap ? 12'd0 : row_inc[11:0];
                    res.image_last = row_wrap;
                end
            end
        end else if (accept) begin
            unique case (r_phase)
                plrle_pkg::PH_CODE,
                plrle_pkg::PH_LOW: begin
                    n_run_is_fill = start_fill;
                    if (r_phase == plrle_pkg::PH_CODE &&
                        i_data_byte[plrle_pkg::CODE_LONG_BIT]) begin
                        n_run_remaining = start_count;
                        n_phase         = plrle_pkg::PH_LOW;
                    end else begin
                        n_run_remaining   = start_count;
                        n_overrun_pending = 1'b0;
                        if (start_fill) begin
                            n_phase = plrle_pkg::PH_BODY;
                        end else if (start_count == 14'd0) begin
                            n_phase = plrle_pkg::PH_CODE;
                        end else begin
                            n_overrun_pending = start_count > {1'b0, rem};
                            n_phase           = plrle_pkg::PH_BODY;
                        end
                    end
                end
                plrle_pkg::PH_BODY: begin
                    res_valid = r_run_is_fill ? (r_run_remaining != 14'd0) : 1'b1;
                    // move along the plane, wrapping plane and row
                    if (res_valid) begin
                        n_col = col_sum[11:0];
                        if (col_done) begin
                            n_col   = 12'd0;
                            n_plane = plane_inc[1:0];
                            if (plane_wrap) begin
                                n_plane        = 2'd0;
                                n_row          = row_wrap ? 12'd0 : row_inc[11:0];
                                res.image_last = row_wrap;
                            end
                        end
                    end
                    if (r_run_is_fill) begin
                        n_phase           = plrle_pkg::PH_CODE;
                        n_run_remaining   = 14'd0;
                        res.run_length    = {1'b0, fill_len};
                        res.overrun_error = fill_clip;
                    end else begin
                        n_run_remaining = rr_dec;
                        if (r_overrun_pending && col_done) begin
                            res.overrun_error = 1'b1;
                            n_overrun_pending = 1'b0;
                            n_phase = (rr_dec != 14'd0) ? plrle_pkg::PH_SKIP
                                                        : plrle_pkg::PH_CODE;
                        end else if (rr_dec == 14'd0) begin
                            n_phase = plrle_pkg::PH_CODE;
                        end
                    end
                end
                plrle_pkg::PH_SKIP: begin
                    // drop literal bytes past the end of the plane row
                    if (r_run_remaining != 14'd0) begin
                        n_run_remaining = rr_dec;
                    end
                    if (r_run_remaining <= 14'd1) begin
                        n_phase = plrle_pkg::PH_CODE;
                    end
                end
                default: n_phase = plrle_pkg::PH_CODE;
            endcase
        end
    end

    // result register with skid stage behind it
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= 13'd1;
            r_image_height    <= 13'd1;
            r_channel_count   <= 3'd4;
            r_rle_mode        <= 1'b1;
            r_phase           <= plrle_pkg::PH_CODE;
            r_run_remaining   <= 14'd0;
            r_run_is_fill     <= 1'b0;
            r_col             <= 12'd0;
            r_plane           <= 2'd0;
            r_row             <= 12'd0;
            r_overrun_pending <= 1'b0;
            r_out_valid       <= 1'b0;
            r_skid_valid      <= 1'b0;
        end else begin
            r_image_width     <= n_image_width;
            r_image_height    <= n_image_height;
            r_channel_count   <= n_channel_count;
            r_rle_mode        <= n_rle_mode;
            r_phase           <= n_phase;
            r_run_remaining   <= n_run_remaining;
            r_run_is_fill     <= n_run_is_fill;
            r_col             <= n_col;
            r_plane           <= n_plane;
            r_row             <= n_row;
            r_overrun_pending <= n_overrun_pending;
            r_out_valid       <= n_out_valid;
            r_skid_valid      <= n_skid_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // ports
    assign o_stall         = r_skid_valid;
    assign o_valid         = r_out_valid;
    assign o_out_value     = r_out.out_value;
    assign o_run_length    = r_out.run_length;
    assign o_out_row       = r_out.out_row;
    assign o_out_col       = r_out.out_col;
    assign o_out_channel   = r_out.out_channel;
    assign o_image_last    = r_out.image_last;
    assign o_overrun_error = r_out.overrun_error;

endmodule

FILE: rtl/plrle_checker.sv
// port checks for the planar run-length image decoder, bound to the top level
`timescale 1ns / 1ps

module plrle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_value,
    input logic [13:0] o_run_length,
    input logic [11:0] o_out_row,
    input logic [11:0] o_out_col
);

    // a stalled result holds its transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_value) &&
        $stable(o_run_length) && $stable(o_out_row) && $stable(o_out_col))
        else $error("stalled result changed");

    // input is only held off while a result is waiting
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending result");

    // every run covers at least one pixel
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_run_length != 14'd0)
        else $error("zero-length run delivered");

    // reset empties the result side
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result side not empty after reset");

endmodule

bind planar_rle_image_decoder_top plrle_checker u_plrle_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_value  (o_out_value),
    .o_run_length (o_run_length),
    .o_out_row    (o_out_row),
    .o_out_col    (o_out_col)
);
